FILE: design/imu_tilt_pkg.sv
// Package for the stationary tilt tracker: widths, register indexes, FSM states,
// the arcsine table and a small saturation helper. No dependencies.
`default_nettype none
package imu_tilt_pkg;
  localparam int Window    = 256;
  localparam int PtrW      = $clog2(Window);
  localparam int WarmW     = $clog2(Window + 1);
  localparam int SumW      = 16 + PtrW;

  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegPeriod    = 2'd1;
  localparam logic [1:0] RegDt        = 2'd2;
  localparam logic [1:0] RegGain      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WRITE, ST_SCAN, ST_DECIDE, ST_TILT, ST_POS, ST_OUT
  } state_e;

  typedef struct packed {
    logic write_ring;
    logic scan_start;
    logic scan_step;
    logic capture;
    logic integrate;
    logic pos_calc;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic at_rest;
  } stat_t;

  function automatic logic signed [15:0] asin_tab(input logic [4:0] i);
    logic signed [15:0] r;
    case (i)
      5'd0: r = 16'sd0;     5'd1: r = 16'sd256;   5'd2: r = 16'sd513;
      5'd3: r = 16'sd773;   5'd4: r = 16'sd1035;  5'd5: r = 16'sd1302;
      5'd6: r = 16'sd1574;  5'd7: r = 16'sd1855;  5'd8: r = 16'sd2145;
      5'd9: r = 16'sd2447;  5'd10: r = 16'sd2765; 5'd11: r = 16'sd3105;
      5'd12: r = 16'sd3474; 5'd13: r = 16'sd3885; 5'd14: r = 16'sd4364;
      5'd15: r = 16'sd4978; default: r = 16'sd6434;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
    if (v > 41'sd32767) return 16'sh7fff;
    if (v < -41'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage
`default_nettype wire

FILE: design/imu_tilt_ctrl.sv
// Sequencer of the tilt tracker: handshakes, warm-up, period count and the
// decision to scan. Uses imu_tilt_pkg.
`default_nettype none
module imu_tilt_ctrl
  import imu_tilt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire logic [15:0] check_period_i,
  input  wire stat_t       stat_i,
  output cmd_t             cmd_o,
  output logic             caught_o
);
  state_e state_q, state_d;
  logic [WarmW-1:0] warm_q, warm_d;
  logic bias_q, bias_d, caught_q, caught_d;
  logic [15:0] pcnt_q, pcnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; warm_q <= WarmW'(Window); bias_q <= 1'b0;
      caught_q <= 1'b0; pcnt_q <= '0;
    end else begin
      state_q <= state_d; warm_q <= warm_d; bias_q <= bias_d;
      caught_q <= caught_d; pcnt_q <= pcnt_d;
    end
  end

  always_comb begin
    state_d = state_q; warm_d = warm_q; bias_d = bias_q; caught_d = caught_q;
    pcnt_d = pcnt_q; cmd_o = '0;
    in_stall_o = 1'b1; out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write_ring = 1'b1;
        caught_d = 1'b0;
        if (warm_q != '0) begin
          warm_d = warm_q - 1'b1;
          state_d = ST_IDLE;
        end else if (!bias_q) begin
          cmd_o.scan_start = 1'b1;
          state_d = ST_SCAN;
        end else if (pcnt_q > check_period_i) begin
          pcnt_d = '0;
          cmd_o.scan_start = 1'b1;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_TILT;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // At the first capture the period count is 0, so no second scan follows.
        if (stat_i.at_rest) begin
          cmd_o.capture = 1'b1;
          caught_d = 1'b1;
          bias_d = 1'b1;
          if (!bias_q && pcnt_q > check_period_i) begin
            pcnt_d = '0;
            cmd_o.scan_start = 1'b1;
            state_d = ST_SCAN;
          end else begin
            state_d = ST_TILT;
          end
        end else if (!bias_q) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_TILT;
        end
      end
      ST_TILT: begin
        cmd_o.integrate = !caught_q;
        if (pcnt_q != 16'hffff) pcnt_d = pcnt_q + 1'b1;
        state_d = ST_POS;
      end
      ST_POS: begin
        cmd_o.pos_calc = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign caught_o = caught_q;
endmodule
`default_nettype wire

FILE: design/imu_tilt_dp.sv
// Datapath of the tilt tracker: sample ring, min/max/sum scan, bias and tilt
// capture, rate integration and position. Uses imu_tilt_pkg.
`default_nettype none
module imu_tilt_dp
  import imu_tilt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_take_i,
  input  wire logic signed [15:0] acc_x_i, acc_y_i, acc_z_i, rate_x_i, rate_y_i,
  input  wire logic [14:0]        thr_i,
  input  wire logic [15:0]        dt_i,
  input  wire logic signed [15:0] gain_i,
  input  wire cmd_t               cmd_i,
  output stat_t                   stat_o,
  output logic signed [15:0]      pos_x_o, pos_y_o, pos_z_o, roll_o, pitch_o
);
  logic [47:0] ring_q [Window];
  logic [47:0] rd_q;
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic signed [15:0] smp_q [5];
  logic signed [15:0] lo_q [3], hi_q [3], bias_q [3], pos_q [3];
  logic signed [SumW-1:0] sum_q [3];
  logic signed [15:0] roll_q, pitch_q;
  logic rd_v_q, first_q, last_q;
  logic signed [15:0] rv [3];

  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      smp_q[0] <= acc_x_i; smp_q[1] <= acc_y_i; smp_q[2] <= acc_z_i;
      smp_q[3] <= rate_x_i; smp_q[4] <= rate_y_i;
    end
    if (cmd_i.write_ring) ring_q[wptr_q] <= {smp_q[2], smp_q[1], smp_q[0]};
    rd_q <= ring_q[rptr_q];
  end

  assign rv[0] = rd_q[15:0];
  assign rv[1] = rd_q[31:16];
  assign rv[2] = rd_q[47:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0; rptr_q <= '0; rd_v_q <= 1'b0; first_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      if (cmd_i.write_ring) wptr_q <= wptr_q + 1'b1;
      if (cmd_i.scan_start) begin
        rptr_q <= '0; rd_v_q <= 1'b0; first_q <= 1'b1; last_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        // Read address runs one ahead of the registered read data.
        rd_v_q <= !last_q;
        if (rptr_q == PtrW'(Window - 1)) last_q <= 1'b1;
        else rptr_q <= rptr_q + 1'b1;
        if (rd_v_q) first_q <= 1'b0;
      end
    end
  end
  assign stat_o.scan_last = cmd_i.scan_step && rd_v_q && last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && rd_v_q) begin
      for (int a = 0; a < 3; a++) begin
        if (first_q) begin
          lo_q[a] <= rv[a]; hi_q[a] <= rv[a]; sum_q[a] <= SumW'(rv[a]);
        end else begin
          if (rv[a] < lo_q[a]) lo_q[a] <= rv[a];
          if (rv[a] > hi_q[a]) hi_q[a] <= rv[a];
          sum_q[a] <= sum_q[a] + SumW'(rv[a]);
        end
      end
    end
  end

  logic [16:0] spread [3];
  always_comb begin
    stat_o.at_rest = 1'b1;
    for (int a = 0; a < 3; a++) begin
      spread[a] = 17'({hi_q[a][15], hi_q[a]} - {lo_q[a][15], lo_q[a]});
      if (spread[a] >= {2'b0, thr_i}) stat_o.at_rest = 1'b0;
    end
  end

  logic signed [15:0] mean [3];
  always_comb for (int a = 0; a < 3; a++) mean[a] = sum_q[a][SumW-1:PtrW];

  function automatic logic signed [15:0] tasin(input logic signed [15:0] m);
    logic neg;
    logic [12:0] mag;
    logic signed [15:0] b0, b1, r;
    logic signed [25:0] p;
    neg = m[15];
    if (m > 16'sd4096) mag = 13'd4096;
    else if (m < -16'sd4096) mag = 13'd4096;
    else mag = neg ? 13'(-m) : 13'(m);
    b0 = asin_tab(mag[12:8]);
    b1 = asin_tab(5'(mag[12:8] + 1'b1));
    p = 26'(b1 - b0) * $signed({18'b0, mag[7:0]}) + 26'sd128;
    r = (mag[12]) ? asin_tab(5'd16) : 16'(b0 + 16'(p >>> 8));
    return neg ? -r : r;
  endfunction

  logic signed [33:0] dr, dp;
  always_comb begin
    dr = (34'(smp_q[3]) * $signed({18'b0, dt_i}) + 34'sd32768) >>> 16;
    dp = (34'(smp_q[4]) * $signed({18'b0, dt_i}) + 34'sd32768) >>> 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q <= '0; pitch_q <= '0;
      for (int a = 0; a < 3; a++) bias_q[a] <= '0;
    end else if (cmd_i.capture) begin
      for (int a = 0; a < 3; a++) bias_q[a] <= mean[a];
      pitch_q <= sat16(-41'(tasin(mean[0])));
      roll_q <= tasin(mean[1]);
    end else if (cmd_i.integrate) begin
      roll_q <= sat16(41'(roll_q) + 41'(dr));
      pitch_q <= sat16(41'(pitch_q) + 41'(dp));
    end
  end

  logic signed [16:0] diff [3];
  logic signed [33:0] prod [3];
  always_comb for (int a = 0; a < 3; a++) begin
    diff[a] = 17'(smp_q[a]) - 17'(bias_q[a]);
    prod[a] = (34'(diff[a]) * 34'(gain_i) + 34'sd128) >>> 8;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_calc) for (int a = 0; a < 3; a++) pos_q[a] <= sat16(41'(prod[a]));
  end

  assign pos_x_o = pos_q[0];
  assign pos_y_o = pos_q[1];
  assign pos_z_o = pos_q[2];
  assign roll_o = roll_q;
  assign pitch_o = pitch_q;
endmodule
`default_nettype wire

FILE: design/imu_stationary_tilt_tracker.sv
// Top level of the stationary tilt tracker: configuration registers and the
// controller/datapath pair. Uses imu_tilt_pkg, imu_tilt_ctrl, imu_tilt_dp.
//
// One IMU sample is a beat on the input channel (in_valid_i / in_stall_o); a
// result is a beat on the output channel (out_valid_o / out_stall_i). The block
// takes one sample at a time. A warm-up sample is only written to the ring and
// gives no result. A plain sample after the first capture runs the write, tilt,
// position and output states. A sample that runs the rest test adds one pass of
// the 256-entry ring through the single read port and a decide step. The period
// count is still zero at the first capture, so no second pass follows it.
// The result stays on the output until taken; while out_stall_i is high no new
// sample is accepted. Reset clears control state, tilt, bias and the register
// defaults (threshold 2048, period 200, dt 655, gain 0); the ring needs no
// clearing since it is read only after the warm-up has filled it.
// Configuration is to be written through cfg_we_i / cfg_idx_i / cfg_data_i
// only while idle; the block itself does not enforce this.
`default_nettype none
module imu_stationary_tilt_tracker
  import imu_tilt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] acc_x_i, acc_y_i, acc_z_i,
  input  wire logic signed [15:0] rate_x_i, rate_y_i, rate_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      pos_x_o, pos_y_o, pos_z_o,
  output logic signed [15:0]      roll_angle_o, pitch_angle_o,
  output logic                    at_rest_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i
);
  logic [14:0] thr_q;
  logic [15:0] per_q, dt_q;
  logic signed [15:0] gain_q;
  cmd_t cmd;
  stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 15'd2048; per_q <= 16'd200; dt_q <= 16'd655; gain_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegThreshold: thr_q <= cfg_data_i[14:0];
        RegPeriod:    per_q <= cfg_data_i;
        RegDt:        dt_q <= cfg_data_i;
        RegGain:      gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  imu_tilt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .check_period_i(per_q), .stat_i(stat), .cmd_o(cmd), .caught_o(at_rest_o)
  );

  imu_tilt_dp u_dp (
    .clk_i, .rst_ni, .in_take_i(in_valid_i && !in_stall_o),
    .acc_x_i, .acc_y_i, .acc_z_i, .rate_x_i, .rate_y_i,
    .thr_i(thr_q), .dt_i(dt_q), .gain_i(gain_q), .cmd_i(cmd), .stat_o(stat),
    .pos_x_o, .pos_y_o, .pos_z_o, .roll_o(roll_angle_o), .pitch_o(pitch_angle_o)
  );

  wire unused_rz = ^rate_z_i;
endmodule
`default_nettype wire

FILE: design/imu_tilt_chk.sv
// Port-level checker for the stationary tilt tracker, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module imu_tilt_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic at_rest_o
);
  // Only one sample is in flight: no input beat while a result waits.
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken with result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o) else $error("result too early");
  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(at_rest_o)) else $error("flag moved");
endmodule

bind imu_stationary_tilt_tracker imu_tilt_chk u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .at_rest_o
);
`default_nettype wire
